// ===== hw/rtl/bpfa_pkg.sv =====
package bpfa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int FRAME_SHIFT = 12;
    localparam int PF_W        = 12;
    localparam int ADDR_W      = 24;
    localparam int CFG_W       = 13;
    localparam int PADDR_W     = 3;

    localparam logic [CFG_W-1:0] CFG_RESET         = 13'd4096;
    localparam logic             REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_TEST  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOTHING = 2'd1,
        ST_NO_FREE = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // command carried by the probe along the cell row
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_SET    = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_TEST   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic found;
        logic used;
    } t_ctl;

    typedef struct packed {
        logic [PF_W-1:0] new_page_frame;
        logic            present;
        logic            read_write;
        logic            user_mode;
        logic            frame_used;
        t_status         status;
    } t_result;

endpackage

// ===== hw/rtl/bpfa_cell.sv =====
module bpfa_cell #(
    parameter int CELL_INDEX = 0,
    parameter int FW         = 12,
    parameter int WCW        = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpfa_pkg::t_ctl  i_ctl,
    input  logic [FW-1:0]   i_frame,
    input  logic [WCW-1:0]  i_lim_words,
    output bpfa_pkg::t_ctl  o_ctl,
    output logic [FW-1:0]   o_frame,
    output logic [WCW-1:0]  o_lim_words
);
    import bpfa_pkg::*;

    localparam int WIW = FW - BIT_W;

    logic [WORD_BITS-1:0] r_word, n_word;
    t_ctl                 r_ctl, n_ctl;
    logic [FW-1:0]        r_frame, n_frame;
    logic [WCW-1:0]       r_lim_words;

    logic                 w_hit;
    logic [BIT_W-1:0]     w_bit;
    logic [BIT_W-1:0]     w_free_idx;
    logic                 w_searchable;

    assign w_hit = (i_frame[FW-1:BIT_W] == WIW'(CELL_INDEX));
    assign w_bit = i_frame[BIT_W-1:0];
    assign w_searchable = (WCW'(CELL_INDEX) < i_lim_words) && (r_word != '1);

    // lowest clear bit of the held word
    always_comb begin
        w_free_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!r_word[b]) begin
                w_free_idx = BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_word  = r_word;
        n_ctl   = i_ctl;
        n_frame = i_frame;
        if (i_ctl.valid) begin
            case (i_ctl.cmd)
                CMD_SEARCH: begin
                    if (!i_ctl.found && w_searchable) begin
                        n_word[w_free_idx] = 1'b1;
                        n_ctl.found        = 1'b1;
                        n_frame            = {WIW'(CELL_INDEX), w_free_idx};
                    end
                end
                CMD_SET: begin
                    if (w_hit) begin
                        n_word[w_bit] = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    if (w_hit) begin
                        n_word[w_bit] = 1'b0;
                    end
                end
                CMD_TEST: begin
                    if (w_hit) begin
                        n_ctl.used = r_word[w_bit];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_ctl  <= '0;
        end else begin
            r_word <= n_word;
            r_ctl  <= n_ctl;
        end
        r_frame     <= n_frame;
        r_lim_words <= i_lim_words;
    end

    assign o_ctl       = r_ctl;
    assign o_frame     = r_frame;
    assign o_lim_words = r_lim_words;

endmodule

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+--------------------------------------------
// request   | in        | i_valid / o_ready   | opcode, page_frame, frame_address, flags
// result    | out       | o_valid / i_ready   | new_page_frame, page bits, frame_used, status
// config    | in        | apb psel / penable  | frames_in_use at byte address 0
//
// a request walks the row of bitmap cells, one cell (32 frames) per cycle, so a
// result appears once the probe has left the last cell and been registered at the output,
// and the next request is taken in that same cycle; the row length sets the rate
// reset (synchronous, active low) clears every bitmap word at once, no sweep
// a result waiting on i_ready holds the output register while the next request runs,
// a second finished result parks in a skid register and stops new requests
module bitmap_page_frame_allocator #(
    parameter int NUM_FRAMES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [bpfa_pkg::PF_W-1:0]      i_page_frame,
    input  logic [bpfa_pkg::ADDR_W-1:0]    i_frame_address,
    input  logic                           i_is_kernel,
    input  logic                           i_is_writable,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bpfa_pkg::PF_W-1:0]      o_new_page_frame,
    output logic                           o_present,
    output logic                           o_read_write,
    output logic                           o_user_mode,
    output logic                           o_frame_used,
    output logic [1:0]                     o_status,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpfa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import bpfa_pkg::*;

    localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FW        = WIW + BIT_W;
    localparam int WCW       = $clog2(NUM_WORDS + 1);
    localparam int LW        = $clog2(NUM_FRAMES + 1);
    localparam int CW        = (LW > CFG_W) ? LW : CFG_W;

    // configuration register
    logic [CFG_W-1:0] r_frames_in_use;

    // request bookkeeping
    logic             r_busy;
    t_op              r_req_op;
    logic [PF_W-1:0]  r_req_pf;
    logic             r_req_kern;
    logic             r_req_wr;
    t_status          r_pre_status;

    // probe launch into the row
    t_ctl             r_ctl0;
    logic [FW-1:0]    r_frame0;
    logic [WCW-1:0]   r_lim0;

    // result and skid registers
    logic             r_out_valid;
    t_result          r_out;
    logic             r_pend_valid;
    t_result          r_pend;

    logic             w_accept;
    logic             w_take;
    logic             w_done;
    logic             w_cfg_wr;
    t_op              w_op;
    logic [CW-1:0]    w_cfg_ext;
    logic [CW-1:0]    w_lim;
    logic [CW-1:0]    w_pf_ext;
    logic [CW-1:0]    w_addr_frame;
    t_cmd             w_cmd;
    t_status          w_pre_status;
    logic [FW-1:0]    w_target;
    logic             w_search;
    t_result          w_res;

    t_ctl             w_ctl   [NUM_WORDS+1];
    logic [FW-1:0]    w_frame [NUM_WORDS+1];
    logic [WCW-1:0]   w_limw  [NUM_WORDS+1];

    // apb: always ready, writes land on the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_FRAMES_IN_USE) ? 32'(r_frames_in_use) : 32'd0;

    assign o_ready  = !r_busy && !r_pend_valid;
    assign w_accept = i_valid && o_ready;
    assign w_take   = r_out_valid && i_ready;

    // effective limit is the smaller of the register and the bitmap size
    assign w_cfg_ext    = CW'(r_frames_in_use);
    assign w_lim        = (w_cfg_ext > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : w_cfg_ext;
    assign w_pf_ext     = CW'(i_page_frame);
    assign w_addr_frame = CW'(i_frame_address[ADDR_W-1:FRAME_SHIFT]);
    assign w_op         = t_op'(i_opcode);

    // decide up front what the probe does and which status is already known
    always_comb begin
        w_cmd        = CMD_NONE;
        w_pre_status = ST_DONE;
        w_target     = '0;
        case (w_op)
            OP_ALLOC: begin
                if (i_page_frame != '0) begin
                    w_pre_status = ST_NOTHING;
                end else begin
                    w_cmd = CMD_SEARCH;
                end
            end
            OP_FREE: begin
                w_target = FW'(w_pf_ext);
                if (i_page_frame == '0) begin
                    w_pre_status = ST_NOTHING;
                end else if (w_pf_ext >= w_lim) begin
                    w_pre_status = ST_RANGE;
                end else begin
                    w_cmd = CMD_CLEAR;
                end
            end
            OP_MARK, OP_TEST: begin
                w_target = FW'(w_addr_frame);
                if (w_addr_frame >= w_lim) begin
                    w_pre_status = ST_RANGE;
                end else if (w_op == OP_MARK) begin
                    w_cmd = CMD_SET;
                end else begin
                    w_cmd = CMD_TEST;
                end
            end
            default: begin
            end
        endcase
    end

    // row of bitmap cells, one word each
    assign w_ctl[0]   = r_ctl0;
    assign w_frame[0] = r_frame0;
    assign w_limw[0]  = r_lim0;

    for (genvar g = 0; g < NUM_WORDS; g++) begin : g_cell
        bpfa_cell #(
            .CELL_INDEX (g),
            .FW         (FW),
            .WCW        (WCW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[g]),
            .i_frame     (w_frame[g]),
            .i_lim_words (w_limw[g]),
            .o_ctl       (w_ctl[g+1]),
            .o_frame     (w_frame[g+1]),
            .o_lim_words (w_limw[g+1])
        );
    end

    assign w_done   = w_ctl[NUM_WORDS].valid;
    assign w_search = (r_req_op == OP_ALLOC) && (r_pre_status == ST_DONE);

    // assemble the result from the probe leaving the last cell
    always_comb begin
        w_res.new_page_frame = r_req_pf;
        w_res.present        = 1'b0;
        w_res.read_write     = 1'b0;
        w_res.user_mode      = 1'b0;
        w_res.frame_used     = w_ctl[NUM_WORDS].used;
        w_res.status         = r_pre_status;
        if (w_search) begin
            if (w_ctl[NUM_WORDS].found) begin
                w_res.new_page_frame = PF_W'(w_frame[NUM_WORDS]);
                w_res.present        = 1'b1;
                w_res.read_write     = r_req_wr;
                w_res.user_mode      = !r_req_kern;
            end else begin
                w_res.status = ST_NO_FREE;
            end
        end else if ((r_req_op == OP_FREE) && (r_pre_status == ST_DONE)) begin
            w_res.new_page_frame = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
            r_busy          <= 1'b0;
            r_ctl0          <= '0;
            r_out_valid     <= 1'b0;
            r_pend_valid    <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
                r_frames_in_use <= pwdata[CFG_W-1:0];
            end

            // probe is a one-cycle pulse into the first cell
            r_ctl0.valid <= w_accept;
            r_ctl0.cmd   <= w_cmd;
            r_ctl0.found <= 1'b0;
            r_ctl0.used  <= 1'b0;

            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end

            // result lands in the output register, or in the skid if that is held
            if (w_done && (!r_out_valid || w_take)) begin
                r_out_valid <= 1'b1;
            end else if (w_done) begin
                r_pend_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end

        if (w_accept) begin
            r_req_op     <= w_op;
            r_req_pf     <= i_page_frame;
            r_req_kern   <= i_is_kernel;
            r_req_wr     <= i_is_writable;
            r_pre_status <= w_pre_status;
        end
        r_frame0 <= w_target;
        r_lim0   <= WCW'(w_lim >> BIT_W);

        if (w_done && (!r_out_valid || w_take)) begin
            r_out <= w_res;
        end else if (w_done) begin
            r_pend <= w_res;
        end else if (w_take && r_pend_valid) begin
            r_out <= r_pend;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_new_page_frame = r_out.new_page_frame;
    assign o_present        = r_out.present;
    assign o_read_write     = r_out.read_write;
    assign o_user_mode      = r_out.user_mode;
    assign o_frame_used     = r_out.frame_used;
    assign o_status         = r_out.status;

endmodule
